/* rtl/core/rspn_pkg.sv */
`default_nettype none

package rspn_pkg;

  // Class and field sizes.
  localparam int NumCls     = 6;
  localparam int MaxClasses = 6;
  localparam int ExpLutBits = 10;
  localparam int LutSize    = 1 << ExpLutBits;
  localparam int ExpW       = 17;
  localparam int TW         = 33;
  localparam int UW         = 34;
  localparam int SumW       = 19;
  localparam int NumW       = 32;
  localparam int QuoW       = 16;
  localparam int RespW      = 16;
  localparam int BitsPerDivStage = 2;
  localparam int DivStages  = QuoW / BitsPerDivStage;
  localparam logic [RespW-1:0] OneQ15 = 16'd32768;

  // Configuration register indexes.
  localparam logic [2:0] RegClassCount = 3'd0;
  localparam logic [2:0] RegPrior0     = 3'd1;
  localparam logic [2:0] RegPrior1     = 3'd2;
  localparam logic [2:0] RegPrior2     = 3'd3;
  localparam logic [2:0] RegPrior3     = 3'd4;
  localparam logic [2:0] RegPrior4     = 3'd5;
  localparam logic [2:0] RegPrior5     = 3'd6;
  localparam logic [3:0] LabelNone     = 4'hF;

  typedef struct packed {
    logic signed [31:0] loglik_0;
    logic signed [31:0] loglik_1;
    logic signed [31:0] loglik_2;
    logic signed [31:0] loglik_3;
    logic signed [31:0] loglik_4;
    logic signed [31:0] loglik_5;
    logic signed [3:0]  label;
    logic               last_row;
  } row_t;

  typedef struct packed {
    logic [15:0] resp_0;
    logic [15:0] resp_1;
    logic [15:0] resp_2;
    logic [15:0] resp_3;
    logic [15:0] resp_4;
    logic [15:0] resp_5;
    logic        label_error;
    logic        last_row_out;
  } res_t;

  // Per-row control that travels down the pipeline next to the data.
  typedef struct packed {
    logic [2:0] k;
    logic       unl;
    logic       err;
    logic [2:0] lab;
    logic       last;
  } ctl_t;

  typedef logic [ExpW-1:0] exp_tab_t [LutSize];

  // Builds the exp(-x) table in Q1.16 from a Taylor series and four squarings.
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [63:0] v;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] w;
    for (int n = 0; n < LutSize; n++) begin
      v    = 64'(n) << (30 - ExpLutBits);
      term = 64'd1 << 30;
      pos  = term;
      neg  = 64'd0;
      for (int q = 1; q <= 14; q++) begin
        term = ((term * v) >> 30) / 64'(q);
        if (q[0]) begin
          neg = neg + term;
        end else begin
          pos = pos + term;
        end
      end
      w = pos - neg;
      for (int s = 0; s < 4; s++) begin
        w = (w * w + (64'd1 << 29)) >> 30;
      end
      tab[n] = ExpW'((w + 64'd8192) >> 14);
    end
    return tab;
  endfunction

  localparam exp_tab_t ExpTab = build_exp_tab();

endpackage

`default_nettype wire

/* rtl/core/rspn_div.sv */
`default_nettype none

module rspn_div (
  input  logic                      clk_i,
  input  logic [rspn_pkg::NumW-1:0] num_i,
  input  logic [rspn_pkg::SumW-1:0] den_i,
  output logic [rspn_pkg::QuoW-1:0] quo_o
);
  import rspn_pkg::*;

  logic [SumW-1:0] rem_q [DivStages];
  logic [QuoW-1:0] low_q [DivStages];
  logic [SumW-1:0] den_q [DivStages];
  logic [QuoW-1:0] quo_q [DivStages];

  // Each stage resolves a few quotient bits by restoring subtraction.
  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    logic [SumW-1:0] rem_in;
    logic [QuoW-1:0] low_in;
    logic [SumW-1:0] den_in;
    logic [QuoW-1:0] quo_in;
    logic [SumW-1:0] rem_d;
    logic [QuoW-1:0] low_d;
    logic [QuoW-1:0] quo_d;
    logic [SumW:0]   trial;

    if (s == 0) begin : g_first
      // The upper half of the numerator is already below the divisor.
      assign rem_in = SumW'(num_i[NumW-1:QuoW]);
      assign low_in = num_i[QuoW-1:0];
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign low_in = low_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    always_comb begin
      rem_d = rem_in;
      low_d = low_in;
      quo_d = quo_in;
      trial = '0;
      for (int b = 0; b < BitsPerDivStage; b++) begin
        trial = {rem_d, low_d[QuoW-1]};
        low_d = {low_d[QuoW-2:0], 1'b0};
        if (trial >= {1'b0, den_in}) begin
          trial = trial - {1'b0, den_in};
          quo_d = {quo_d[QuoW-2:0], 1'b1};
        end else begin
          quo_d = {quo_d[QuoW-2:0], 1'b0};
        end
        rem_d = trial[SumW-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s] <= rem_d;
      low_q[s] <= low_d;
      den_q[s] <= den_in;
      quo_q[s] <= quo_d;
    end
  end

  assign quo_o = quo_q[DivStages-1];

endmodule

`default_nettype wire

/* rtl/core/responsibility_normalizer.sv */
// Pipeline: done_o and res_o carry the result of each accepted row after 18 register stages.
// Throughput: one row per cycle; busy is always low, as the pipeline never stalls.
// The depth is set by the max search, the exp table read, the sum and the
// eight-stage divider (two quotient bits per stage).
// Reset clears the valid bits and sets class_count to 6 and all log priors to 0.
`default_nettype none

module responsibility_normalizer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  rspn_pkg::row_t    row_i,
  output logic              done_o,
  output rspn_pkg::res_t    res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import rspn_pkg::*;

  localparam int Depth = 18;

  // Configuration registers.
  logic [2:0]         cc_q;
  logic signed [31:0] prior_q [NumCls];
  logic [2:0]         ridx;

  assign ridx   = paddr[4:2];
  assign pready = 1'b1;
  assign busy   = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q <= 3'd6;
      for (int i = 0; i < NumCls; i++) prior_q[i] <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        RegClassCount: cc_q       <= pwdata[2:0];
        RegPrior0:     prior_q[0] <= pwdata;
        RegPrior1:     prior_q[1] <= pwdata;
        RegPrior2:     prior_q[2] <= pwdata;
        RegPrior3:     prior_q[3] <= pwdata;
        RegPrior4:     prior_q[4] <= pwdata;
        RegPrior5:     prior_q[5] <= pwdata;
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    unique case (ridx)
      RegClassCount: prdata = {29'd0, cc_q};
      RegPrior0:     prdata = prior_q[0];
      RegPrior1:     prdata = prior_q[1];
      RegPrior2:     prdata = prior_q[2];
      RegPrior3:     prdata = prior_q[3];
      RegPrior4:     prdata = prior_q[4];
      RegPrior5:     prdata = prior_q[5];
      default:       prdata = '0;
    endcase
  end

  // Control pipeline.
  logic accept;
  logic vld_q [Depth];
  ctl_t ctl_q [Depth];
  ctl_t ctl_d;

  assign accept = start && !busy;

  always_comb begin
    ctl_d.k    = (cc_q == 3'd0) ? 3'd1 :
                 (cc_q > 3'(MaxClasses)) ? 3'(MaxClasses) : cc_q;
    ctl_d.unl  = (row_i.label == LabelNone);
    ctl_d.err  = !ctl_d.unl && (row_i.label[3] || (row_i.label[2:0] >= ctl_d.k));
    ctl_d.lab  = row_i.label[2:0];
    ctl_d.last = row_i.last_row;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < Depth; j++) vld_q[j] <= 1'b0;
    end else begin
      vld_q[0] <= accept;
      for (int j = 1; j < Depth; j++) vld_q[j] <= vld_q[j-1];
    end
  end

  always_ff @(posedge clk_i) begin
    ctl_q[0] <= ctl_d;
    for (int j = 1; j < Depth; j++) ctl_q[j] <= ctl_q[j-1];
  end

  // Stage 1: add the log priors; classes not in use copy class 0.
  logic signed [31:0] ll [NumCls];
  logic signed [TW-1:0] t1_d [NumCls];
  logic signed [TW-1:0] t1_q [NumCls];

  assign ll[0] = row_i.loglik_0;
  assign ll[1] = row_i.loglik_1;
  assign ll[2] = row_i.loglik_2;
  assign ll[3] = row_i.loglik_3;
  assign ll[4] = row_i.loglik_4;
  assign ll[5] = row_i.loglik_5;

  always_comb begin
    for (int i = 0; i < NumCls; i++) begin
      t1_d[i] = TW'(ll[i]) + TW'(prior_q[i]);
    end
    for (int i = 1; i < NumCls; i++) begin
      if (3'(i) >= ctl_d.k) t1_d[i] = t1_d[0];
    end
  end

  always_ff @(posedge clk_i) begin
    t1_q <= t1_d;
  end

  // Stages 2 and 3: maximum over the classes.
  logic signed [TW-1:0] t2_q [NumCls];
  logic signed [TW-1:0] mx2_q [NumCls/2];
  logic signed [TW-1:0] t3_q [NumCls];
  logic signed [TW-1:0] m3_q;
  logic signed [TW-1:0] m01;

  always_ff @(posedge clk_i) begin
    t2_q <= t1_q;
    for (int p = 0; p < NumCls/2; p++) begin
      mx2_q[p] <= (t1_q[2*p+1] > t1_q[2*p]) ? t1_q[2*p+1] : t1_q[2*p];
    end
  end

  assign m01 = (mx2_q[1] > mx2_q[0]) ? mx2_q[1] : mx2_q[0];

  always_ff @(posedge clk_i) begin
    t3_q <= t2_q;
    m3_q <= (mx2_q[2] > m01) ? mx2_q[2] : m01;
  end

  // Stage 4: distance from the maximum becomes a table address.
  logic [ExpLutBits-1:0] addr4_q [NumCls];
  logic                  inr4_q  [NumCls];
  logic [UW-1:0]         u4      [NumCls];

  always_comb begin
    for (int i = 0; i < NumCls; i++) begin
      u4[i] = UW'(m3_q) - UW'(t3_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NumCls; i++) begin
      addr4_q[i] <= u4[i][19 -: ExpLutBits];
      inr4_q[i]  <= (u4[i][UW-1:20] == '0) && (3'(i) < ctl_q[2].k);
    end
  end

  // Stage 5: registered table read.
  logic [ExpW-1:0] e5_q [NumCls];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NumCls; i++) begin
      e5_q[i] <= inr4_q[i] ? ExpTab[addr4_q[i]] : '0;
    end
  end

  // Stages 6 and 7: sum of the exp terms.
  logic [ExpW-1:0] e6_q [NumCls];
  logic [ExpW:0]   p6_q [NumCls/2];
  logic [ExpW-1:0] e7_q [NumCls];
  logic [SumW-1:0] s7_q;

  always_ff @(posedge clk_i) begin
    e6_q <= e5_q;
    for (int p = 0; p < NumCls/2; p++) begin
      p6_q[p] <= (ExpW+1)'(e5_q[2*p]) + (ExpW+1)'(e5_q[2*p+1]);
    end
  end

  always_ff @(posedge clk_i) begin
    e7_q <= e6_q;
    s7_q <= SumW'(p6_q[0]) + SumW'(p6_q[1]) + SumW'(p6_q[2]);
  end

  // Stage 8: rounded numerators.
  logic [NumW-1:0] n8_q [NumCls];
  logic [SumW-1:0] d8_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NumCls; i++) begin
      n8_q[i] <= (NumW'(e7_q[i]) << 15) + NumW'(s7_q >> 1);
    end
    d8_q <= s7_q;
  end

  // Stages 9 to 16: one pipelined divider per class.
  logic [QuoW-1:0] r16 [NumCls];

  for (genvar i = 0; i < NumCls; i++) begin : g_div
    rspn_div u_div (
      .clk_i (clk_i),
      .num_i (n8_q[i]),
      .den_i (d8_q),
      .quo_o (r16[i])
    );
  end

  // Stage 17: total given to the classes below the last.
  logic [QuoW-1:0] r17_q [NumCls];
  logic [SumW-1:0] given17_q;
  logic [SumW-1:0] given_d;

  always_comb begin
    given_d = '0;
    for (int i = 0; i < NumCls; i++) begin
      if (3'(i) + 3'd1 < ctl_q[15].k) given_d = given_d + SumW'(r16[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    r17_q     <= r16;
    given17_q <= given_d;
  end

  // Stage 18: output register.
  logic [RespW-1:0] rest;
  logic [RespW-1:0] resp_d [NumCls];
  logic [RespW-1:0] resp_q [NumCls];
  logic             err_q;
  logic             last_q;
  ctl_t             c17;

  assign c17  = ctl_q[16];
  assign rest = (given17_q >= SumW'(OneQ15)) ? '0 : RespW'(SumW'(OneQ15) - given17_q);

  always_comb begin
    for (int i = 0; i < NumCls; i++) begin
      if (c17.unl) begin
        if (3'(i) + 3'd1 < c17.k) begin
          resp_d[i] = r17_q[i];
        end else if (3'(i) + 3'd1 == c17.k) begin
          resp_d[i] = rest;
        end else begin
          resp_d[i] = '0;
        end
      end else if (!c17.err && (c17.lab == 3'(i))) begin
        resp_d[i] = OneQ15;
      end else begin
        resp_d[i] = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    resp_q <= resp_d;
    err_q  <= c17.err;
    last_q <= c17.last;
  end

  assign done_o             = vld_q[Depth-1];
  assign res_o.resp_0       = resp_q[0];
  assign res_o.resp_1       = resp_q[1];
  assign res_o.resp_2       = resp_q[2];
  assign res_o.resp_3       = resp_q[3];
  assign res_o.resp_4       = resp_q[4];
  assign res_o.resp_5       = resp_q[5];
  assign res_o.label_error  = err_q;
  assign res_o.last_row_out = last_q;

endmodule

`default_nettype wire

/* tb/resp_checker.sv */
`timescale 1ns / 100ps

module resp_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  logic            busy,
  input  rspn_pkg::row_t  row_i,
  input  logic            done_o,
  input  rspn_pkg::res_t  res_o,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [4:0]      paddr,
  input  logic [31:0]     pwdata,
  input  logic            pready,
  output int              fail_count,
  output int              pending_count
);
  import rspn_pkg::*;

  logic [2:0]         cls_cnt;
  logic signed [31:0] prior [6];
  logic [16:0]        exp_lut [LutSize];
  res_t               resp_q [$];

  // Build the exp(-x) table in Q1.16 from a truncated series and four squarings.
  initial begin
    logic [63:0] v, term, pos, neg, w;
    for (int n = 0; n < LutSize; n++) begin
      v    = 64'(n) << (30 - ExpLutBits);
      term = 64'd1 << 30;
      pos  = term;
      neg  = 0;
      for (int q = 1; q <= 14; q++) begin
        term = ((term * v) >> 30) / 64'(q);
        if (q % 2 == 1) begin
          neg += term;
        end else begin
          pos += term;
        end
      end
      w = pos - neg;
      for (int s = 0; s < 4; s++) begin
        w = (w * w + (64'd1 << 29)) >> 30;
      end
      exp_lut[n] = 17'((w + 64'd8192) >> 14);
    end
  end

  // Compute the responsibilities for one row under the current registers.
  function automatic res_t normalize(row_t r);
    res_t                 o;
    logic signed [31:0]   ll [6];
    logic signed [33:0]   t [6];
    logic signed [33:0]   m;
    logic [33:0]          u;
    logic [63:0]          e [6];
    logic [63:0]          sum, given, q;
    logic [15:0]          rv [6];
    int                   k;
    ll = '{r.loglik_0, r.loglik_1, r.loglik_2, r.loglik_3, r.loglik_4, r.loglik_5};
    k = cls_cnt;
    if (k == 0) k = 1;
    if (k > MaxClasses) k = MaxClasses;
    rv = '{default: '0};
    o = '0;
    o.last_row_out = r.last_row;
    if (r.label == LabelNone) begin
      for (int i = 0; i < k; i++) t[i] = 34'(ll[i]) + 34'(prior[i]);
      m = t[0];
      for (int i = 1; i < k; i++) if (t[i] > m) m = t[i];
      sum = 0;
      for (int i = 0; i < k; i++) begin
        u = m - t[i];
        e[i] = (u >= (34'd16 << 16)) ? 64'd0 : 64'(exp_lut[u >> (20 - ExpLutBits)]);
        sum += e[i];
      end
      if (sum == 0) sum = 1;
      given = 0;
      for (int i = 0; i + 1 < k; i++) begin
        q = (e[i] * 32768 + sum / 2) / sum;
        rv[i] = q[15:0];
        given += q;
      end
      rv[k-1] = (given >= 32768) ? 16'd0 : 16'(32768 - given);
    end else if (r.label[3] || int'(r.label) >= k) begin
      o.label_error = 1'b1;
    end else begin
      rv[r.label] = OneQ15;
    end
    o.resp_0 = rv[0]; o.resp_1 = rv[1]; o.resp_2 = rv[2];
    o.resp_3 = rv[3]; o.resp_4 = rv[4]; o.resp_5 = rv[5];
    return o;
  endfunction

  // Track register writes, predict accepted rows and check each result.
  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      cls_cnt <= 3'd6;
      for (int i = 0; i < 6; i++) prior[i] <= '0;
      resp_q.delete();
      fail_count <= 0;
      pending_count <= 0;
    end else begin
      if (done_o) begin
        if (resp_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, res_o);
          fail_count <= fail_count + 1;
        end else begin
          want = resp_q.pop_front();
          if (res_o !== want) begin
            $display("%0t: mismatch expected %h actual %h", $time, want, res_o);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) resp_q.push_back(normalize(row_i));
      pending_count <= resp_q.size();
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          RegClassCount: cls_cnt <= pwdata[2:0];
          RegPrior0: prior[0] <= pwdata;
          RegPrior1: prior[1] <= pwdata;
          RegPrior2: prior[2] <= pwdata;
          RegPrior3: prior[3] <= pwdata;
          RegPrior4: prior[4] <= pwdata;
          RegPrior5: prior[5] <= pwdata;
          default: ;
        endcase
      end
    end
  end
endmodule

/* tb/tb_responsibility_normalizer.sv */
`timescale 1ns / 100ps

module tb_responsibility_normalizer;
  import rspn_pkg::*;

  logic        clk_i, rst_ni, start, busy, done_o;
  row_t        row_i;
  res_t        res_o;
  logic        psel, penable, pwrite, pready;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          fail_count, pending_count;

  responsibility_normalizer dut (.*);

  resp_checker u_checker (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("tb_responsibility_normalizer failed");
    $finish;
  end

  // One register write: setup cycle then access cycle.
  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Wait until all results are back, then let the pipeline settle.
  task automatic drain();
    while (pending_count != 0) @(negedge clk_i);
    repeat (24) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom;
      default: return 32'(int'($urandom_range(0, 20 << 16)) - (10 << 16));
    endcase
  endfunction

  // Present one row; it is held until accepted, with a random gap before it when gaps is set.
  task automatic send_row(row_t r, bit gaps);
    if (gaps) begin
      start <= 1'b0;
      repeat ($urandom_range(0, 8)) @(negedge clk_i);
    end
    start <= 1'b1;
    row_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic row_t rand_row(int lab_mode);
    row_t r;
    r.loglik_0 = rand_val(); r.loglik_1 = rand_val(); r.loglik_2 = rand_val();
    r.loglik_3 = rand_val(); r.loglik_4 = rand_val(); r.loglik_5 = rand_val();
    r.label = (lab_mode != 0 || $urandom_range(0, 3) == 0) ? 4'($urandom) : LabelNone;
    r.last_row = 1'($urandom);
    return r;
  endfunction

  initial begin
    row_t r;
    bit   gaps;
    start = 1'b0; row_i = '0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    paddr = '0; pwdata = '0;
    rst_ni = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed rows at reset settings: extremes, equal values, every label.
    r = '0; r.label = LabelNone;
    send_row(r, 0);
    r.loglik_0 = 32'h7fff_ffff; r.loglik_1 = 32'h8000_0000;
    send_row(r, 0);
    r = '{default: 32'h8000_0000, label: LabelNone, last_row: 1'b1};
    send_row(r, 0);
    r = '{default: 32'hffff_ffff, label: LabelNone, last_row: 1'b0};
    r.loglik_3 = 32'h0010_0000;
    send_row(r, 1);
    for (int l = 0; l < 16; l++) begin
      r = rand_row(1);
      r.label = 4'(l);
      send_row(r, 1);
    end
    start <= 1'b0;
    drain();

    // Phases across register settings, extremes first.
    for (int ph = 0; ph < 12; ph++) begin
      reg_write(RegClassCount, (ph < 8) ? 32'(ph) : 32'($urandom_range(0, 7)));
      reg_write(RegPrior0, (ph == 1) ? 32'h8000_0000 : rand_val());
      reg_write(RegPrior1, (ph == 1) ? 32'h7fff_ffff : rand_val());
      reg_write(RegPrior2, rand_val());
      reg_write(RegPrior3, rand_val());
      reg_write(RegPrior4, rand_val());
      reg_write(RegPrior5, (ph == 2) ? 32'h0 : rand_val());
      reg_write(3'd7, $urandom);
      gaps = (ph % 3 != 0);
      for (int n = 0; n < 86; n++) send_row(rand_row(0), gaps);
      start <= 1'b0;
      drain();
    end

    if (fail_count == 0) begin
      $display("tb_responsibility_normalizer passed");
    end else begin
      $display("tb_responsibility_normalizer failed");
    end
    $finish;
  end
endmodule
